### design/dwc_pkg.sv
`default_nettype none
package dwc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CNT_W      = 3;
  localparam int STAR_RUN   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BANNED_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_FIRST   = 3'd1;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_COMMA) || (b == CH_PERIOD) ||
           (b == CH_UNDER) || (b == CH_APOS) || (b == CH_QUOTE);
  endfunction

endpackage
`default_nettype wire

### design/dwc_if.sv
`default_nettype none
interface dwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_char;

  modport source (output valid, output in_byte, output last_char, input ready);
  modport sink   (input valid, input in_byte, input last_char, output ready);
endinterface

interface dwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface
`default_nettype wire

### design/dwc_cfg.sv
`default_nettype none
module dwc_cfg #(
  parameter int WORD_SLOTS = 6,
  parameter int WORD_BYTES = 8,
  parameter int LW         = $clog2(WORD_BYTES + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dwc_pkg::cfg_wr_t        wr,
  output logic [WORD_BYTES*8-1:0]      word [WORD_SLOTS],
  output logic [LW-1:0]                wlen [WORD_SLOTS],
  output logic [WORD_SLOTS-1:0]        slot_en
);
  import dwc_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic [WORD_BYTES*8-1:0] word_r [WORD_SLOTS];
  logic [LW-1:0]           wlen_r [WORD_SLOTS];
  logic [LW-1:0]           new_len;

  // word ends at first zero byte
  always_comb begin
    new_len = LW'(WORD_BYTES);
    for (int i = WORD_BYTES - 1; i >= 0; i--) begin
      if (wr.wdata[8*i +: 8] == 8'h00) begin
        new_len = LW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (wr.we && wr.index == REG_BANNED_COUNT) begin
      count_r <= wr.wdata[CNT_W-1:0];
    end
  end

  for (genvar s = 0; s < WORD_SLOTS; s++) begin : g_slot
    logic hit;
    assign hit = wr.we && (wr.index == CFG_IDX_W'(int'(REG_WORD_FIRST) + s));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        wlen_r[s] <= '0;
      end else if (hit) begin
        wlen_r[s] <= new_len;
      end
    end

    always_ff @(posedge clk) begin
      if (hit) begin
        word_r[s] <= wr.wdata[WORD_BYTES*8-1:0];
      end
    end

    assign word[s]    = word_r[s];
    assign wlen[s]    = wlen_r[s];
    assign slot_en[s] = count_r > CNT_W'(s);
  end

endmodule
`default_nettype wire

### design/dwc_match.sv
`default_nettype none
module dwc_match #(
  parameter int WORD_SLOTS = 6,
  parameter int WORD_BYTES = 8,
  parameter int LW         = $clog2(WORD_BYTES + 1)
) (
  input  wire logic [WORD_BYTES*8-1:0] word [WORD_SLOTS],
  input  wire logic [LW-1:0]           wlen [WORD_SLOTS],
  input  wire logic [WORD_SLOTS-1:0]   slot_en,
  input  wire logic [WORD_BYTES*8-1:0] m_bytes,
  input  wire logic [LW-1:0]           m_len,
  input  wire logic [7:0]              d_byte,
  output logic                         tok_hit,
  output logic                         delim_hit
);

  always_comb begin
    logic hit_s;
    tok_hit   = 1'b0;
    delim_hit = 1'b0;
    for (int s = 0; s < WORD_SLOTS; s++) begin
      hit_s = slot_en[s] && (m_len != '0) && (wlen[s] == m_len);
      for (int i = 0; i < WORD_BYTES; i++) begin
        if ((LW'(i) < m_len) && (word[s][8*i +: 8] != m_bytes[8*i +: 8])) begin
          hit_s = 1'b0;
        end
      end
      tok_hit   = tok_hit | hit_s;
      delim_hit = delim_hit |
                  (slot_en[s] && (wlen[s] == LW'(1)) && (word[s][7:0] == d_byte));
    end
  end

endmodule
`default_nettype wire

### design/dwc_core.sv
`default_nettype none
module dwc_core #(
  parameter int WORD_SLOTS = 6,
  parameter int WORD_BYTES = 8,
  parameter int LW         = $clog2(WORD_BYTES + 1),
  parameter int BURST      = WORD_BYTES + 3,
  parameter int BW         = $clog2(BURST + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  dwc_in_if.sink                       in_ch,
  input  wire logic [WORD_BYTES*8-1:0] word [WORD_SLOTS],
  input  wire logic [LW-1:0]           wlen [WORD_SLOTS],
  input  wire logic [WORD_SLOTS-1:0]   slot_en,
  input  wire logic                    burst_free,
  output logic                         load,
  output logic [7:0]                   burst_bytes [BURST],
  output logic [BW-1:0]                burst_len
);
  import dwc_pkg::*;

  logic                    s1_v_r;
  logic [7:0]              s1_byte_r;
  logic                    s1_last_r;
  logic [LW-1:0]           tlen_r, tlen_nxt;
  logic                    pt_r, pt_nxt;
  logic [7:0]              tok_r [WORD_BYTES];

  logic                    go;
  logic                    is_d, is_nl, full, tok_wr;
  logic [WORD_BYTES*8-1:0] tok_ext;
  logic [LW-1:0]           m_len, f_len;
  logic                    f_match, sfx_star;
  logic                    tok_hit, delim_hit;
  logic [BW-1:0]           pre_len, sfx_len;

  assign is_d  = is_delim(s1_byte_r);
  assign is_nl = (s1_byte_r == CH_NL);
  assign full  = (tlen_r == LW'(WORD_BYTES));

  // pending token with the new byte placed after it
  for (genvar i = 0; i < WORD_BYTES; i++) begin : g_ext
    assign tok_ext[8*i +: 8] = (tlen_r == LW'(i)) ? s1_byte_r : tok_r[i];
  end

  assign m_len = is_d ? tlen_r : tlen_r + LW'(1);

  dwc_match #(
    .WORD_SLOTS (WORD_SLOTS),
    .WORD_BYTES (WORD_BYTES),
    .LW         (LW)
  ) u_match (
    .word      (word),
    .wlen      (wlen),
    .slot_en   (slot_en),
    .m_bytes   (tok_ext),
    .m_len     (m_len),
    .d_byte    (s1_byte_r),
    .tok_hit   (tok_hit),
    .delim_hit (delim_hit)
  );

  always_comb begin
    f_len    = '0;
    f_match  = 1'b0;
    sfx_len  = '0;
    sfx_star = 1'b0;
    tok_wr   = 1'b0;
    tlen_nxt = tlen_r;
    pt_nxt   = pt_r;
    if (is_d) begin
      f_len    = tlen_r;
      f_match  = tok_hit;
      sfx_len  = delim_hit ? BW'(STAR_RUN) : BW'(1);
      sfx_star = delim_hit;
      tlen_nxt = '0;
      pt_nxt   = 1'b0;
    end else if (pt_r) begin
      sfx_len = BW'(1);
      pt_nxt  = !is_nl;
    end else if (full) begin
      f_len    = tlen_r;
      sfx_len  = BW'(1);
      tlen_nxt = '0;
      pt_nxt   = !is_nl;
    end else begin
      tok_wr = 1'b1;
      if (is_nl || s1_last_r) begin
        f_len    = m_len;
        f_match  = tok_hit;
        tlen_nxt = '0;
      end else begin
        tlen_nxt = m_len;
      end
    end
    if (s1_last_r) begin
      pt_nxt = 1'b0;
    end
  end

  assign pre_len   = (f_len == '0) ? '0 : (f_match ? BW'(STAR_RUN) : BW'(f_len));
  assign burst_len = pre_len + sfx_len;

  for (genvar i = 0; i < BURST; i++) begin : g_burst
    logic [7:0] pre_b;
    if (i < WORD_BYTES) begin : g_tok
      assign pre_b = f_match ? CH_STAR : tok_ext[8*i +: 8];
    end else begin : g_star
      assign pre_b = CH_STAR;
    end
    assign burst_bytes[i] = (BW'(i) < pre_len) ? pre_b :
                            (sfx_star ? CH_STAR : s1_byte_r);
  end

  assign go          = s1_v_r && (burst_free || burst_len == '0);
  assign load        = go && (burst_len != '0);
  assign in_ch.ready = !s1_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      tlen_r <= '0;
      pt_r   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_v_r <= 1'b1;
      end else if (go) begin
        s1_v_r <= 1'b0;
      end
      if (go) begin
        tlen_r <= tlen_nxt;
        pt_r   <= pt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.in_byte;
      s1_last_r <= in_ch.last_char;
    end
  end

  for (genvar i = 0; i < WORD_BYTES; i++) begin : g_tok_wr
    always_ff @(posedge clk) begin
      if (go && tok_wr && tlen_r == LW'(i)) begin
        tok_r[i] <= s1_byte_r;
      end
    end
  end

`ifndef SYNTH
  a_pt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pt_r |-> (tlen_r == '0))
    else $error("pass-through with pending token bytes");

  a_tlen_max: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r <= LW'(WORD_BYTES))
    else $error("token length beyond storage");
`endif

endmodule
`default_nettype wire

### design/dwc_burst.sv
`default_nettype none
module dwc_burst #(
  parameter int BURST = 11,
  parameter int BW    = $clog2(BURST + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire logic [7:0]    burst_bytes [BURST],
  input  wire logic [BW-1:0] burst_len,
  output logic               free,
  dwc_out_if.source          out_ch
);

  logic [7:0]    sreg_r [BURST];
  logic [BW-1:0] cnt_r;
  logic          take;

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.out_byte = sreg_r[0];
  assign out_ch.run_end  = (cnt_r == BW'(1));
  assign take            = out_ch.valid && out_ch.ready;
  assign free            = (cnt_r == '0) || (out_ch.run_end && out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst_len;
    end else if (take) begin
      cnt_r <= cnt_r - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sreg_r <= burst_bytes;
    end else if (take) begin
      for (int i = 0; i < BURST - 1; i++) begin
        sreg_r[i] <= sreg_r[i+1];
      end
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("burst loaded over pending words");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= BW'(BURST))
    else $error("burst count out of range");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_ch.run_end) |=> out_ch.valid)
    else $error("burst ended without run_end");
`endif

endmodule
`default_nettype wire

### design/delimited_word_censor.sv
`default_nettype none
// Streaming banned-word filter. Text bytes enter on in_ch and are grouped into tokens at
// space, comma, period, underscore, apostrophe and double quote; a newline closes the token
// it ends. A token equal to one of the first banned_count banned words leaves as "***", as
// does a delimiter equal to a one-byte banned word; anything else leaves unchanged, one
// byte per out_ch word with run_end on the last word that an input byte causes. An input
// byte is registered, evaluated combinationally, and its output run (up to WORD_BYTES+3
// words) is loaded into an output shift register once that register is free, which offers it on out_ch.
// Bytes that emit at most one word stream at one per cycle while
// out_ch is ready; a byte that closes a token holds the next byte in the input register
// until the shift register has drained its run, one word per cycle while out_ch is ready.
// Configuration: cfg_index 0 is banned_count, 1 to 6 the banned words (bytes from the low
// end, ending at the first zero byte); write only while no input byte is in flight.
module delimited_word_censor #(
  parameter int WORD_SLOTS = 6,
  parameter int WORD_BYTES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dwc_in_if.sink                                 in_ch,
  dwc_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [dwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dwc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dwc_pkg::*;

  localparam int LW    = $clog2(WORD_BYTES + 1);
  localparam int BURST = WORD_BYTES + 3;
  localparam int BW    = $clog2(BURST + 1);

  cfg_wr_t                 wr;
  logic [WORD_BYTES*8-1:0] word [WORD_SLOTS];
  logic [LW-1:0]           wlen [WORD_SLOTS];
  logic [WORD_SLOTS-1:0]   slot_en;
  logic                    burst_free;
  logic                    load;
  logic [7:0]              burst_bytes [BURST];
  logic [BW-1:0]           burst_len;

  assign wr.we    = cfg_we;
  assign wr.index = cfg_index;
  assign wr.wdata = cfg_wdata;

  dwc_cfg #(
    .WORD_SLOTS (WORD_SLOTS),
    .WORD_BYTES (WORD_BYTES),
    .LW         (LW)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .word    (word),
    .wlen    (wlen),
    .slot_en (slot_en)
  );

  dwc_core #(
    .WORD_SLOTS (WORD_SLOTS),
    .WORD_BYTES (WORD_BYTES),
    .LW         (LW),
    .BURST      (BURST),
    .BW         (BW)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .word        (word),
    .wlen        (wlen),
    .slot_en     (slot_en),
    .burst_free  (burst_free),
    .load        (load),
    .burst_bytes (burst_bytes),
    .burst_len   (burst_len)
  );

  dwc_burst #(
    .BURST (BURST),
    .BW    (BW)
  ) u_burst (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .burst_bytes (burst_bytes),
    .burst_len   (burst_len),
    .free        (burst_free),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
